// ===== rtl/volume_box_mean_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the box mean filter.
// ----------------------------------------------------------------------------
`ifndef VOLUME_BOX_MEAN_FILTER_ASSERT_SVH
`define VOLUME_BOX_MEAN_FILTER_ASSERT_SVH

// Property holds in the same cycle as its trigger.
`define VBM_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Property holds in the cycle after its trigger.
`define VBM_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/vbm_pkg.sv =====
// ----------------------------------------------------------------------------
// vbm_pkg
// Types and constants shared by the box mean filter modules.
// ----------------------------------------------------------------------------
package vbm_pkg;

  localparam int X_W     = 6;
  localparam int Y_W     = 6;
  localparam int Z_W     = 16;
  localparam int DIM_W   = 7;
  localparam int VOX_W   = 16;
  localparam int RING_W  = 3;
  localparam int ADDR_W  = RING_W + Y_W + X_W;
  localparam int SUM_W   = 25;
  localparam int MAG_W   = 24;
  localparam int RCP_W   = 29;
  localparam int RCP_SH  = 33;
  localparam int PROD_W  = MAG_W + RCP_W;
  localparam int MAX_DIM = 64;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_DEPTH  = 2'd3;

  typedef struct packed {
    logic [1:0]       r;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [Z_W-1:0]   d;
  } vbm_cfg_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
    logic           last;
  } vbm_job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VOX_W-1:0]  data;
  } vbm_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_FLUSH,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } vbm_state_t;

  // Rounded-up reciprocal of the window size, scaled by 2**RCP_SH. Exact for
  // every magnitude below 2**MAG_W. A radius of zero bypasses the multiply.
  function automatic logic [RCP_W-1:0] window_recip(input logic [1:0] r);
    logic [RCP_W-1:0] n;
    case (r)
      2'd1:    n = 29'd318145726;
      2'd2:    n = 29'd68719477;
      2'd3:    n = 29'd25043542;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/vbm_store.sv =====
// ----------------------------------------------------------------------------
// vbm_store
// Ring of slices holding received voxels: one write and one read port.
// ----------------------------------------------------------------------------
module vbm_store
  import vbm_pkg::*;
(
  input  logic              clk,
  input  vbm_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [VOX_W-1:0]  rd_data
);

  logic [VOX_W-1:0] mem [2**ADDR_W];
  logic [VOX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/vbm_front.sv =====
// ----------------------------------------------------------------------------
// vbm_front
// Tracks input and output positions, stores voxels and queues due outputs.
// ----------------------------------------------------------------------------
module vbm_front
  import vbm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  vbm_cfg_t         cfg,
  input  logic             restart,
  input  logic             back_busy,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [VOX_W-1:0] in_voxel,
  input  logic             in_drain,
  output vbm_wr_t          wr,
  output logic             job_valid,
  output vbm_job_t         job,
  input  logic             job_pop
);

  logic [X_W-1:0] in_x_r, in_x_nxt, ox_r, ox_nxt;
  logic [Y_W-1:0] in_y_r, in_y_nxt, oy_r, oy_nxt;
  logic [Z_W-1:0] in_z_r, in_z_nxt, oz_r, oz_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           wp_r, rp_r;
  vbm_job_t       q_r [2];

  logic             acc, do_wr, due, last;
  logic [X_W-1:0]   ix;
  logic [Y_W-1:0]   iy;
  logic [Z_W-1:0]   iz;
  logic [DIM_W-1:0] xs, ys, nx, ny;
  logic [Z_W:0]     zs;
  logic [Z_W-1:0]   nz;
  logic             push;

  assign in_tready = (cnt_r == 2'd0) && !back_busy;
  assign acc       = in_tvalid && in_tready;
  assign do_wr     = !in_drain && (in_z_r < cfg.d);

  always_comb begin
    ix = in_x_r;
    iy = in_y_r;
    iz = in_z_r;
    if (do_wr) begin
      if ({1'b0, in_x_r} + 7'd1 == cfg.w) begin
        ix = '0;
        if ({1'b0, in_y_r} + 7'd1 == cfg.h) begin
          iy = '0;
          iz = in_z_r + 16'd1;
        end else begin
          iy = in_y_r + 6'd1;
        end
      end else begin
        ix = in_x_r + 6'd1;
      end
    end
  end

  always_comb begin
    xs = {1'b0, ox_r} + {5'd0, cfg.r};
    ys = {1'b0, oy_r} + {5'd0, cfg.r};
    zs = {1'b0, oz_r} + {15'd0, cfg.r};
    nx = (xs >= cfg.w) ? cfg.w - 7'd1 : xs;
    ny = (ys >= cfg.h) ? cfg.h - 7'd1 : ys;
    nz = (zs >= {1'b0, cfg.d}) ? cfg.d - 16'd1 : zs[Z_W-1:0];
    due = (iz > nz) || ((iz == nz) && (({1'b0, iy} > ny) ||
          (({1'b0, iy} == ny) && ({1'b0, ix} > nx))));
    last = ({1'b0, ox_r} == cfg.w - 7'd1) && ({1'b0, oy_r} == cfg.h - 7'd1) &&
           (oz_r == cfg.d - 16'd1);
  end

  assign push = acc && due;

  always_comb begin
    in_x_nxt = in_x_r;
    in_y_nxt = in_y_r;
    in_z_nxt = in_z_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    oz_nxt   = oz_r;
    if (acc) begin
      in_x_nxt = ix;
      in_y_nxt = iy;
      in_z_nxt = iz;
    end
    if (push) begin
      if ({1'b0, ox_r} + 7'd1 == cfg.w) begin
        ox_nxt = '0;
        if ({1'b0, oy_r} + 7'd1 == cfg.h) begin
          oy_nxt = '0;
          oz_nxt = oz_r + 16'd1;
        end else begin
          oy_nxt = oy_r + 6'd1;
        end
      end else begin
        ox_nxt = ox_r + 6'd1;
      end
    end
    if (restart || (push && last)) begin
      in_x_nxt = '0;
      in_y_nxt = '0;
      in_z_nxt = '0;
      ox_nxt   = '0;
      oy_nxt   = '0;
      oz_nxt   = '0;
    end
  end

  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, job_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_x_r <= '0;
      in_y_r <= '0;
      in_z_r <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      oz_r   <= '0;
      cnt_r  <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
    end else begin
      in_x_r <= in_x_nxt;
      in_y_r <= in_y_nxt;
      in_z_r <= in_z_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
      cnt_r  <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (job_pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{x: ox_r, y: oy_r, z: oz_r, last: last};
    end
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign wr.en     = acc && do_wr;
  assign wr.addr   = {in_z_r[RING_W-1:0], in_y_r, in_x_r};
  assign wr.data   = in_voxel;

endmodule

// ===== rtl/vbm_back.sv =====
// ----------------------------------------------------------------------------
// vbm_back
// Sums one output's window from the store and divides by the window size.
// ----------------------------------------------------------------------------
`include "volume_box_mean_filter_assert.svh"

module vbm_back
  import vbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  vbm_cfg_t          cfg,
  input  logic              job_valid,
  input  vbm_job_t          job,
  output logic              job_pop,
  output logic              busy,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [VOX_W-1:0]  rd_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [VOX_W-1:0]  out_mean,
  output logic              out_last
);

  vbm_state_t state_r, state_nxt;
  vbm_job_t   job_r;
  logic [2:0] dx_r, dy_r, dz_r;
  logic       vld_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [MAG_W-1:0] mag_r;
  logic [RCP_W-1:0] rcp_r;
  logic [VOX_W-1:0] quo_r;
  logic             neg_r;

  logic [2:0]       span;
  logic             step_end, rd_en;
  logic signed [7:0]  xt, yt;
  logic signed [17:0] zt;
  logic [X_W-1:0]   xc;
  logic [Y_W-1:0]   yc;
  logic [Z_W-1:0]   zc;
  logic [PROD_W-1:0] prod;
  logic [VOX_W-1:0] quo_neg;

  assign span     = {cfg.r, 1'b0};
  assign step_end = (dx_r == span) && (dy_r == span) && (dz_r == span);

  always_comb begin
    xt = $signed({2'b0, job_r.x}) + $signed({5'b0, dx_r}) - $signed({6'b0, cfg.r});
    yt = $signed({2'b0, job_r.y}) + $signed({5'b0, dy_r}) - $signed({6'b0, cfg.r});
    zt = $signed({2'b0, job_r.z}) + $signed({15'b0, dz_r}) - $signed({16'b0, cfg.r});
    if (xt < 0) begin
      xc = '0;
    end else if (xt[6:0] >= cfg.w) begin
      xc = X_W'(cfg.w - 7'd1);
    end else begin
      xc = xt[X_W-1:0];
    end
    if (yt < 0) begin
      yc = '0;
    end else if (yt[6:0] >= cfg.h) begin
      yc = Y_W'(cfg.h - 7'd1);
    end else begin
      yc = yt[Y_W-1:0];
    end
    if (zt < 0) begin
      zc = '0;
    end else if (zt[16:0] >= {1'b0, cfg.d}) begin
      zc = cfg.d - 16'd1;
    end else begin
      zc = zt[Z_W-1:0];
    end
  end

  assign rd_addr = {zc[RING_W-1:0], yc, xc};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (job_valid) state_nxt = ST_ACC;
      ST_ACC:   if (step_end) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_OUT;
      ST_OUT:   if (out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = 1'b0;
    rd_en      = 1'b0;
    busy       = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE:  job_pop = job_valid;
      ST_ACC: begin
        rd_en = 1'b1;
        busy  = 1'b1;
      end
      ST_FLUSH: busy = 1'b1;
      ST_OUT:   out_tvalid = 1'b1;
      default:  job_pop = 1'b0;
    endcase
  end

  assign prod = mag_r * rcp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
      dx_r  <= '0;
      dy_r  <= '0;
      dz_r  <= '0;
      sum_r <= '0;
    end else begin
      if (rd_en) begin
        if (dx_r == span) begin
          dx_r <= '0;
          if (dy_r == span) begin
            dy_r <= '0;
            dz_r <= dz_r + 3'd1;
          end else begin
            dy_r <= dy_r + 3'd1;
          end
        end else begin
          dx_r <= dx_r + 3'd1;
        end
      end
      if (vld_r) begin
        sum_r <= sum_r + SUM_W'($signed(rd_data));
      end
    end
    if (state_r == ST_PREP) begin
      neg_r <= sum_r[SUM_W-1];
      mag_r <= sum_r[SUM_W-1] ? MAG_W'(-sum_r) : sum_r[MAG_W-1:0];
      rcp_r <= window_recip(cfg.r);
    end else if (state_r == ST_DIV) begin
      quo_r <= (cfg.r == 2'd0) ? mag_r[VOX_W-1:0] : prod[RCP_SH+VOX_W-1:RCP_SH];
    end
  end

  assign quo_neg  = -quo_r;
  assign out_mean = neg_r ? quo_neg : quo_r;
  assign out_last = job_r.last;

  `VBM_ASSERT_SAME(a_read_in_acc, vld_r, state_r == ST_FLUSH || state_r == ST_ACC,
                   "store data arrived outside accumulation")
  `VBM_ASSERT_NEXT(a_pop_starts, job_pop, state_r == ST_ACC,
                   "job taken without starting accumulation")
  `VBM_ASSERT_NEXT(a_div_done, state_r == ST_DIV, state_r == ST_OUT,
                   "divider did not finish in one cycle")

endmodule

// ===== rtl/volume_box_mean_filter.sv =====
// ----------------------------------------------------------------------------
// volume_box_mean_filter
// 3-D box mean filter over a raster voxel stream with edge replication.
// ----------------------------------------------------------------------------
// Channel   Direction  Words
// in_       slave      tdata = voxel_value, tuser = drain
// out_      master     tdata = mean_value, tlast = last_voxel
// cfg_      write      index 0 radius, 1 width, 2 height, 3 depth
//
// A word producing no output does not hold up the next word. A word producing
// an output has its result offered after a queue pop, one store read per window
// voxel, a flush, a sign step and a reciprocal multiply. The next word is taken
// only once the queue is empty and the flush is done.
// A stalled result lets one further word into the queue, then blocks input.
// Reset is synchronous and clears all positions; the store is not cleared.
// ----------------------------------------------------------------------------
module volume_box_mean_filter
  import vbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] voxel_value
  input  logic        in_tuser,   // [0] drain
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] mean_value
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [1:0]       radius_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [Z_W-1:0]   depth_r;
  vbm_cfg_t         cfg;
  vbm_wr_t          wr;
  vbm_job_t         job;
  logic             job_valid, job_pop, back_busy;
  logic [ADDR_W-1:0] rd_addr;
  logic [VOX_W-1:0]  rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 2'd1;
      width_r  <= 7'd64;
      height_r <= 7'd64;
      depth_r  <= 16'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS: radius_r <= cfg_wdata[1:0];
        REG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        REG_DEPTH:  depth_r  <= cfg_wdata;
        default:    radius_r <= radius_r;
      endcase
    end
  end

  always_comb begin
    cfg.r = radius_r;
    cfg.w = (width_r == '0) ? 7'd1 : ((width_r > 7'(MAX_DIM)) ? 7'(MAX_DIM) : width_r);
    cfg.h = (height_r == '0) ? 7'd1 :
            ((height_r > 7'(MAX_DIM)) ? 7'(MAX_DIM) : height_r);
    cfg.d = (depth_r == '0) ? 16'd1 : depth_r;
  end

  vbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .restart   (cfg_we),
    .back_busy (back_busy),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_voxel  (in_tdata),
    .in_drain  (in_tuser),
    .wr        (wr),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  vbm_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vbm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .busy       (back_busy),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_mean   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
